// File: rtl/core/gnt_pkg.sv
// Shared types, constants and helpers for the grammar-notation tokenizer.
// Depends on nothing; every module of the block imports it.
package gnt_pkg;

    localparam int POSITION_BITS = 16;
    localparam int TOKEN_W = 16;
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
    localparam int WIDE_W = 33;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [WIDE_W-1:0] TOKEN_MAX = WIDE_W'({TOKEN_W{1'b1}});

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        KIND_ERROR   = 4'd0,
        KIND_DOT     = 4'd1,
        KIND_LPAREN  = 4'd2,
        KIND_RPAREN  = 4'd3,
        KIND_OR      = 4'd4,
        KIND_AND     = 4'd5,
        KIND_PLUS    = 4'd6,
        KIND_QMARK   = 4'd7,
        KIND_BANG    = 4'd8,
        KIND_STAR    = 4'd9,
        KIND_MINUS   = 4'd10,
        KIND_CHAR    = 4'd11,
        KIND_QUOTE   = 4'd12,
        KIND_RANGE   = 4'd13,
        KIND_RULE    = 4'd14,
        KIND_BRACKET = 4'd15
    } tok_kind_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_string;
    } char_in_t;

    typedef struct packed {
        tok_kind_t          token_kind;
        logic [TOKEN_W-1:0] token_start;
        logic [TOKEN_W-1:0] token_length;
        logic               last_token;
    } token_out_t;

    typedef struct packed {
        logic       pre_vld;
        token_out_t pre_tok;
        logic       main_vld;
        token_out_t main_tok;
    } res_push_t;

    function automatic logic [TOKEN_W-1:0] sat_token(input logic [WIDE_W-1:0] v);
        return (v > TOKEN_MAX) ? TOKEN_W'(TOKEN_MAX) : v[TOKEN_W-1:0];
    endfunction

    function automatic token_out_t mk_tok(input tok_kind_t kind,
                                          input logic [POSITION_BITS-1:0] start,
                                          input logic [WIDE_W-1:0] len,
                                          input logic last);
        token_out_t t;
        t.token_kind = kind;
        t.token_start = sat_token(WIDE_W'(start));
        t.token_length = sat_token(len);
        t.last_token = last;
        return t;
    endfunction

    function automatic logic [WIDE_W-1:0] span(input logic [POSITION_BITS-1:0] b,
                                               input logic [POSITION_BITS-1:0] cur);
        return (cur >= b) ? (WIDE_W'(cur) - WIDE_W'(b) + WIDE_W'(1)) : WIDE_W'(1);
    endfunction

    function automatic logic is_rule_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
    endfunction

endpackage

// File: rtl/core/gnt_scan.sv
// Scanner state and per-character token logic of the tokenizer.
// Depends on gnt_pkg; produces up to two tokens for each accepted character.
module gnt_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  gnt_pkg::char_in_t in_data,
    output gnt_pkg::res_push_t push
);
    import gnt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPACE1,
        ST_SPACE2,
        ST_CHARLIT,
        ST_QUOTE,
        ST_RANGE,
        ST_RULE
    } scan_state_t;

    scan_state_t              state_reg, state_next;
    logic [2:0]               sub_reg, sub_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [7:0]               prev_reg, prev_next;
    logic                     disc_reg, disc_next;

    logic [7:0]               c;
    logic                     eos;
    logic                     do_start;
    logic                     do_fail;
    logic                     range_ok;
    res_push_t                res;

    always_comb begin
        c = in_data.text_char;
        eos = in_data.end_of_string;
        state_next = state_reg;
        sub_next = sub_reg;
        begin_next = begin_reg;
        disc_next = disc_reg;
        do_start = 1'b0;
        do_fail = 1'b0;
        range_ok = 1'b0;
        res.pre_vld = 1'b0;
        res.pre_tok = mk_tok(KIND_AND, begin_reg, WIDE_W'(1), 1'b0);
        res.main_vld = 1'b0;
        res.main_tok = mk_tok(KIND_ERROR, begin_reg, span(begin_reg, pos_reg), 1'b1);

        if (disc_reg) begin
            res.main_vld = eos;
        end else begin
            case (state_reg)
                ST_SPACE1: begin
                    if (c == CH_BAR) begin
                        if (eos) begin
                            res.pre_vld = 1'b1;
                            res.main_vld = 1'b1;
                            res.main_tok = mk_tok(KIND_ERROR, pos_reg, WIDE_W'(1), 1'b1);
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_SPACE2;
                        end
                    end else begin
                        res.pre_vld = 1'b1;
                        do_start = 1'b1;
                    end
                end
                ST_SPACE2: begin
                    if (c == CH_SPACE) begin
                        res.main_vld = 1'b1;
                        res.main_tok = mk_tok(KIND_OR, begin_reg, WIDE_W'(3), eos);
                        state_next = ST_IDLE;
                    end else begin
                        res.pre_vld = 1'b1;
                        begin_next = (begin_reg < POS_MAX) ? begin_reg + 1'b1 : begin_reg;
                        do_fail = 1'b1;
                    end
                end
                ST_CHARLIT: begin
                    if (sub_reg == 3'd1) begin
                        if (c == CH_NUL || eos) begin
                            do_fail = 1'b1;
                        end else begin
                            sub_next = (c == CH_BSLASH) ? 3'd2 : 3'd3;
                        end
                    end else if (sub_reg == 3'd2) begin
                        if (c == CH_APOS) begin
                            res.main_vld = 1'b1;
                            res.main_tok = mk_tok(KIND_CHAR, begin_reg,
                                                  span(begin_reg, pos_reg), eos);
                            state_next = ST_IDLE;
                        end else if (c == CH_NUL || eos) begin
                            do_fail = 1'b1;
                        end else begin
                            sub_next = 3'd3;
                        end
                    end else begin
                        if (c == CH_APOS) begin
                            res.main_vld = 1'b1;
                            res.main_tok = mk_tok(KIND_CHAR, begin_reg,
                                                  span(begin_reg, pos_reg), eos);
                            state_next = ST_IDLE;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                end
                ST_QUOTE: begin
                    if (c == CH_DQUOTE && prev_reg != CH_BSLASH) begin
                        res.main_vld = 1'b1;
                        res.main_tok = mk_tok(KIND_QUOTE, begin_reg,
                                              span(begin_reg, pos_reg), eos);
                        state_next = ST_IDLE;
                    end else if (c == CH_NUL || eos) begin
                        do_fail = 1'b1;
                    end
                end
                ST_RANGE: begin
                    if (sub_reg == 3'd1 || sub_reg == 3'd4) begin
                        range_ok = (c != CH_NUL);
                    end else if (sub_reg == 3'd2 || sub_reg == 3'd3) begin
                        range_ok = (c == CH_DOT);
                    end else begin
                        range_ok = (c == CH_RBRACE);
                    end
                    if (!range_ok) begin
                        do_fail = 1'b1;
                    end else if (sub_reg >= 3'd5) begin
                        res.main_vld = 1'b1;
                        res.main_tok = mk_tok(KIND_RANGE, begin_reg,
                                              span(begin_reg, pos_reg), eos);
                        state_next = ST_IDLE;
                    end else if (eos) begin
                        do_fail = 1'b1;
                    end else begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
                ST_RULE: begin
                    if (is_rule_char(c)) begin
                        if (eos) begin
                            res.main_vld = 1'b1;
                            res.main_tok = mk_tok(KIND_RULE, begin_reg,
                                                  span(begin_reg, pos_reg), 1'b1);
                            state_next = ST_IDLE;
                        end
                    end else begin
                        res.pre_vld = 1'b1;
                        res.pre_tok = mk_tok(KIND_RULE, begin_reg,
                                             (pos_reg > begin_reg) ?
                                             (WIDE_W'(pos_reg) - WIDE_W'(begin_reg)) :
                                             WIDE_W'(1), 1'b0);
                        do_start = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
        end

        if (do_start) begin
            begin_next = pos_reg;
            state_next = ST_IDLE;
            sub_next = 3'd0;
            case (c)
                CH_DOT: begin
                    res.main_vld = 1'b1;
                    res.main_tok = mk_tok(KIND_DOT, pos_reg, WIDE_W'(1), eos);
                end
                CH_LPAREN: begin
                    res.main_vld = 1'b1;
                    res.main_tok = mk_tok(KIND_LPAREN, pos_reg, WIDE_W'(1), eos);
                end
                CH_RPAREN: begin
                    res.main_vld = 1'b1;
                    res.main_tok = mk_tok(KIND_RPAREN, pos_reg, WIDE_W'(1), eos);
                end
                CH_PLUS: begin
                    res.main_vld = 1'b1;
                    res.main_tok = mk_tok(KIND_PLUS, pos_reg, WIDE_W'(1), eos);
                end
                CH_QMARK: begin
                    res.main_vld = 1'b1;
                    res.main_tok = mk_tok(KIND_QMARK, pos_reg, WIDE_W'(1), eos);
                end
                CH_BANG: begin
                    res.main_vld = 1'b1;
                    res.main_tok = mk_tok(KIND_BANG, pos_reg, WIDE_W'(1), eos);
                end
                CH_STAR: begin
                    res.main_vld = 1'b1;
                    res.main_tok = mk_tok(KIND_STAR, pos_reg, WIDE_W'(1), eos);
                end
                CH_MINUS: begin
                    res.main_vld = 1'b1;
                    res.main_tok = mk_tok(KIND_MINUS, pos_reg, WIDE_W'(1), eos);
                end
                CH_LBRACK, CH_RBRACK: begin
                    res.main_vld = 1'b1;
                    res.main_tok = mk_tok(KIND_BRACKET, pos_reg, WIDE_W'(1), eos);
                end
                CH_SPACE: begin
                    if (eos) begin
                        res.main_vld = 1'b1;
                        res.main_tok = mk_tok(KIND_AND, pos_reg, WIDE_W'(1), 1'b1);
                    end else begin
                        state_next = ST_SPACE1;
                    end
                end
                CH_APOS: begin
                    if (eos) begin
                        do_fail = 1'b1;
                    end else begin
                        state_next = ST_CHARLIT;
                        sub_next = 3'd1;
                    end
                end
                CH_DQUOTE: begin
                    if (eos) begin
                        do_fail = 1'b1;
                    end else begin
                        state_next = ST_QUOTE;
                    end
                end
                CH_LBRACE: begin
                    if (eos) begin
                        do_fail = 1'b1;
                    end else begin
                        state_next = ST_RANGE;
                        sub_next = 3'd1;
                    end
                end
                default: begin
                    if (is_rule_char(c)) begin
                        if (eos) begin
                            res.main_vld = 1'b1;
                            res.main_tok = mk_tok(KIND_RULE, pos_reg, WIDE_W'(1), 1'b1);
                        end else begin
                            state_next = ST_RULE;
                        end
                    end else begin
                        do_fail = 1'b1;
                    end
                end
            endcase
        end

        if (do_fail) begin
            state_next = ST_IDLE;
            if (eos) begin
                res.main_vld = 1'b1;
                res.main_tok = mk_tok(KIND_ERROR, begin_next,
                                      span(begin_next, pos_reg), 1'b1);
            end else begin
                disc_next = 1'b1;
            end
        end

        if (eos) begin
            state_next = ST_IDLE;
            sub_next = 3'd0;
            pos_next = '0;
            begin_next = '0;
            prev_next = CH_NUL;
            disc_next = 1'b0;
        end else begin
            pos_next = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : POS_MAX;
            prev_next = c;
        end

        push = res;
        push.pre_vld = res.pre_vld & accept;
        push.main_vld = res.main_vld & accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sub_reg <= 3'd0;
            pos_reg <= '0;
            begin_reg <= '0;
            prev_reg <= CH_NUL;
            disc_reg <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
            sub_reg <= sub_next;
            pos_reg <= pos_next;
            begin_reg <= begin_next;
            prev_reg <= prev_next;
            disc_reg <= disc_next;
        end
    end

endmodule

// File: rtl/core/gnt_res_fifo.sv
// Result queue of the tokenizer: takes up to two tokens a cycle, gives one while m_ready is high.
// Depends on gnt_pkg for the token type and the queue depth.
module gnt_res_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  gnt_pkg::res_push_t  push,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output gnt_pkg::token_out_t m_data
);
    import gnt_pkg::*;

    token_out_t           mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [1:0]           n_push;
    logic                 pop;
    token_out_t           first_tok;

    always_comb begin
        n_push = {1'b0, push.pre_vld} + {1'b0, push.main_vld};
        first_tok = push.pre_vld ? push.pre_tok : push.main_tok;
        pop = m_valid && m_ready;
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next = count_reg + RES_CNT_W'(n_push) - RES_CNT_W'(pop);
        room = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
        m_valid = (count_reg != '0);
        m_data = mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem[wr_ptr_reg] <= first_tok;
        end
        if (n_push == 2'd2) begin
            mem[wr_ptr_reg + RES_PTR_W'(1)] <= push.main_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/grammar_notation_tokenizer.sv
// Top level of the grammar-notation tokenizer: scanner plus result queue.
// Depends on gnt_pkg, gnt_scan and gnt_res_fifo.
//
// The block takes one character per cycle while s_ready is high and decides its tokens in
// the same cycle, so a character transfer can follow in every cycle that the queue has room.
// A character gives zero, one or two tokens, which enter a four-entry result queue; tokens
// leave it one per cycle while m_ready is high. The input is ready whenever the queue holds
// at most two tokens, so a stream that gives no more than one token per character runs at
// one character per cycle while the output is drained every cycle, and the output port's
// rate of one token per cycle bounds the rest.
module grammar_notation_tokenizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gnt_pkg::char_in_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gnt_pkg::token_out_t m_data
);
    import gnt_pkg::*;

    logic      accept;
    logic      room;
    res_push_t push;

    assign accept = s_valid && s_ready;
    assign s_ready = room;

    gnt_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_data (s_data),
        .push    (push)
    );

    gnt_res_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Every string ends with at least one token.
    a_end_gives_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.end_of_string) |-> (push.pre_vld || push.main_vld))
        else $error("final character of a string gave no token");

    // Only the final character of a string may mark a token as last.
    a_last_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.end_of_string) |->
            !(push.main_vld && push.main_tok.last_token))
        else $error("last token flagged before end of string");

    // A leading token of a pair is never the last one.
    a_pre_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.pre_vld |-> (!push.pre_tok.last_token && push.pre_tok.token_kind != KIND_ERROR))
        else $error("leading token of a pair has wrong kind or last flag");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for grammar_notation_tokenizer: directed and random strings.
// Depends on gnt_pkg and the tokenizer RTL; predicts every token and compares each transfer.
module tb_top;
    import gnt_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int UNSIGNED_MAX16 = 65535;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_SPACE1,
        SCAN_SPACE2,
        SCAN_CHARLIT,
        SCAN_QUOTE,
        SCAN_RANGE,
        SCAN_RULE
    } scan_t;

    typedef struct {
        char_in_t data;
        int       gap_after;
    } pending_char_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    char_in_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    token_out_t m_data;

    pending_char_t chars_to_send[$];
    token_out_t    expected_tokens[$];
    logic [7:0]    text_buf[$];

    int idle_level = 1;
    int gap_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int tokens_seen = 0;
    bit char_taken = 1'b0;

    scan_t       sc_state = SCAN_IDLE;
    int unsigned sc_step = 0;
    int unsigned sc_pos = 0;
    int unsigned sc_begin = 0;
    logic [7:0]  sc_prev = '0;
    bit          sc_drop = 1'b0;

    grammar_notation_tokenizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    function automatic bit name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic int unsigned span_of(input int unsigned b, input int unsigned cur);
        return (cur >= b) ? cur - b + 1 : 1;
    endfunction

    task automatic push_tok(input tok_kind_t kind, input int unsigned start,
                            input int unsigned len, input bit last);
        token_out_t t;
        t.token_kind = kind;
        t.token_start = (start > UNSIGNED_MAX16) ? 16'hFFFF : start[15:0];
        t.token_length = (len > UNSIGNED_MAX16) ? 16'hFFFF : len[15:0];
        t.last_token = last;
        expected_tokens.push_back(t);
    endtask

    task automatic give_up(input int unsigned cur, input bit eos);
        sc_state = SCAN_IDLE;
        if (eos) begin
            push_tok(KIND_ERROR, sc_begin, span_of(sc_begin, cur), 1'b1);
        end else begin
            sc_drop = 1'b1;
        end
    endtask

    task automatic open_token(input logic [7:0] c, input int unsigned cur, input bit eos);
        sc_begin = cur;
        sc_state = SCAN_IDLE;
        sc_step = 0;
        case (c)
            CH_DOT:    push_tok(KIND_DOT, cur, 1, eos);
            CH_LPAREN: push_tok(KIND_LPAREN, cur, 1, eos);
            CH_RPAREN: push_tok(KIND_RPAREN, cur, 1, eos);
            CH_PLUS:   push_tok(KIND_PLUS, cur, 1, eos);
            CH_QMARK:  push_tok(KIND_QMARK, cur, 1, eos);
            CH_BANG:   push_tok(KIND_BANG, cur, 1, eos);
            CH_STAR:   push_tok(KIND_STAR, cur, 1, eos);
            CH_MINUS:  push_tok(KIND_MINUS, cur, 1, eos);
            CH_LBRACK, CH_RBRACK: push_tok(KIND_BRACKET, cur, 1, eos);
            CH_SPACE: begin
                if (eos) push_tok(KIND_AND, cur, 1, 1'b1);
                else sc_state = SCAN_SPACE1;
            end
            CH_APOS: begin
                if (eos) begin
                    give_up(cur, 1'b1);
                end else begin
                    sc_state = SCAN_CHARLIT;
                    sc_step = 1;
                end
            end
            CH_DQUOTE: begin
                if (eos) give_up(cur, 1'b1);
                else sc_state = SCAN_QUOTE;
            end
            CH_LBRACE: begin
                if (eos) begin
                    give_up(cur, 1'b1);
                end else begin
                    sc_state = SCAN_RANGE;
                    sc_step = 1;
                end
            end
            default: begin
                if (name_char(c)) begin
                    if (eos) push_tok(KIND_RULE, cur, 1, 1'b1);
                    else sc_state = SCAN_RULE;
                end else begin
                    give_up(cur, eos);
                end
            end
        endcase
    endtask

    task automatic predict_tokens(input char_in_t ci);
        logic [7:0]  c;
        bit          eos;
        bit          ok;
        int unsigned cur;
        c = ci.text_char;
        eos = ci.end_of_string;
        cur = sc_pos;
        if (sc_drop) begin
            if (eos) push_tok(KIND_ERROR, sc_begin, span_of(sc_begin, cur), 1'b1);
        end else begin
            case (sc_state)
                SCAN_SPACE1: begin
                    if (c == CH_BAR) begin
                        if (eos) begin
                            push_tok(KIND_AND, sc_begin, 1, 1'b0);
                            push_tok(KIND_ERROR, cur, 1, 1'b1);
                            sc_state = SCAN_IDLE;
                        end else begin
                            sc_state = SCAN_SPACE2;
                        end
                    end else begin
                        push_tok(KIND_AND, sc_begin, 1, 1'b0);
                        open_token(c, cur, eos);
                    end
                end
                SCAN_SPACE2: begin
                    if (c == CH_SPACE) begin
                        push_tok(KIND_OR, sc_begin, 3, eos);
                        sc_state = SCAN_IDLE;
                    end else begin
                        push_tok(KIND_AND, sc_begin, 1, 1'b0);
                        if (sc_begin < UNSIGNED_MAX16) sc_begin++;
                        give_up(cur, eos);
                    end
                end
                SCAN_CHARLIT: begin
                    if (sc_step == 1) begin
                        if (c == CH_NUL || eos) give_up(cur, eos);
                        else sc_step = (c == CH_BSLASH) ? 2 : 3;
                    end else if (sc_step == 2) begin
                        if (c == CH_APOS) begin
                            push_tok(KIND_CHAR, sc_begin, span_of(sc_begin, cur), eos);
                            sc_state = SCAN_IDLE;
                        end else if (c == CH_NUL || eos) begin
                            give_up(cur, eos);
                        end else begin
                            sc_step = 3;
                        end
                    end else begin
                        if (c == CH_APOS) begin
                            push_tok(KIND_CHAR, sc_begin, span_of(sc_begin, cur), eos);
                            sc_state = SCAN_IDLE;
                        end else begin
                            give_up(cur, eos);
                        end
                    end
                end
                SCAN_QUOTE: begin
                    if (c == CH_DQUOTE && sc_prev != CH_BSLASH) begin
                        push_tok(KIND_QUOTE, sc_begin, span_of(sc_begin, cur), eos);
                        sc_state = SCAN_IDLE;
                    end else if (c == CH_NUL || eos) begin
                        give_up(cur, eos);
                    end
                end
                SCAN_RANGE: begin
                    if (sc_step == 1 || sc_step == 4) ok = (c != CH_NUL);
                    else if (sc_step == 2 || sc_step == 3) ok = (c == CH_DOT);
                    else ok = (c == CH_RBRACE);
                    if (!ok) begin
                        give_up(cur, eos);
                    end else if (sc_step >= 5) begin
                        push_tok(KIND_RANGE, sc_begin, span_of(sc_begin, cur), eos);
                        sc_state = SCAN_IDLE;
                    end else if (eos) begin
                        give_up(cur, 1'b1);
                    end else begin
                        sc_step++;
                    end
                end
                SCAN_RULE: begin
                    if (name_char(c)) begin
                        if (eos) begin
                            push_tok(KIND_RULE, sc_begin, span_of(sc_begin, cur), 1'b1);
                            sc_state = SCAN_IDLE;
                        end
                    end else begin
                        push_tok(KIND_RULE, sc_begin, (cur > sc_begin) ? cur - sc_begin : 1, 1'b0);
                        open_token(c, cur, eos);
                    end
                end
                default: open_token(c, cur, eos);
            endcase
        end
        sc_prev = c;
        if (eos) begin
            sc_state = SCAN_IDLE;
            sc_step = 0;
            sc_pos = 0;
            sc_begin = 0;
            sc_prev = '0;
            sc_drop = 1'b0;
        end else if (sc_pos < UNSIGNED_MAX16) begin
            sc_pos++;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_token(input token_out_t got);
        token_out_t want;
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("token %0d unexpected: kind %0d start %0d length %0d last %0b",
                                      tokens_seen, got.token_kind, got.token_start,
                                      got.token_length, got.last_token));
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
            got.token_length !== want.token_length || got.last_token !== want.last_token) begin
            report_mismatch($sformatf("token %0d: got %0d/%0d/%0d/%0b, want %0d/%0d/%0d/%0b",
                                      tokens_seen, got.token_kind, got.token_start,
                                      got.token_length, got.last_token, want.token_kind,
                                      want.token_start, want.token_length, want.last_token));
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (idle_level == 0) return 0;
        if (idle_level == 1) begin
            if (r < 75) return 0;
            if (r < 95) return $urandom_range(3, 1);
            return $urandom_range(20, 4);
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(4, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255, 1));
    endfunction

    function automatic logic [7:0] name_byte();
        int r;
        r = $urandom_range(52);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] op_byte();
        case ($urandom_range(9))
            0: return CH_DOT;
            1: return CH_LPAREN;
            2: return CH_RPAREN;
            3: return CH_PLUS;
            4: return CH_QMARK;
            5: return CH_BANG;
            6: return CH_STAR;
            7: return CH_MINUS;
            8: return CH_LBRACK;
            default: return CH_RBRACK;
        endcase
    endfunction

    task automatic append_token();
        int         n;
        logic [7:0] b;
        case ($urandom_range(11))
            0, 1: text_buf.push_back(op_byte());
            2: begin
                text_buf.push_back(CH_SPACE);
                text_buf.push_back(CH_BAR);
                text_buf.push_back(CH_SPACE);
            end
            3: text_buf.push_back(CH_SPACE);
            4: begin
                text_buf.push_back(CH_APOS);
                if ($urandom_range(2) == 0) text_buf.push_back(CH_BSLASH);
                text_buf.push_back(any_byte());
                text_buf.push_back(CH_APOS);
            end
            5, 6: begin
                text_buf.push_back(CH_DQUOTE);
                n = $urandom_range(6);
                repeat (n) begin
                    b = any_byte();
                    if (b == CH_DQUOTE) begin
                        text_buf.push_back(CH_BSLASH);
                    end
                    text_buf.push_back(b);
                end
                text_buf.push_back(CH_DQUOTE);
            end
            7: begin
                text_buf.push_back(CH_LBRACE);
                text_buf.push_back(any_byte());
                text_buf.push_back(CH_DOT);
                text_buf.push_back(CH_DOT);
                text_buf.push_back(any_byte());
                text_buf.push_back(CH_RBRACE);
            end
            8, 9, 10: begin
                n = $urandom_range(8, 1);
                repeat (n) text_buf.push_back(name_byte());
            end
            default: text_buf.push_back(any_byte());
        endcase
    endtask

    task automatic build_random_text();
        int n;
        int pick;
        int pos;
        text_buf.delete();
        pick = $urandom_range(99);
        if (pick < 6) begin
            n = $urandom_range(8, 1);
            repeat (n) text_buf.push_back(($urandom_range(19) == 0) ? CH_NUL : any_byte());
        end else begin
            n = $urandom_range(5, 1);
            repeat (n) append_token();
            if (pick < 12) begin
                pos = $urandom_range(text_buf.size() - 1);
                text_buf[pos] = ($urandom_range(9) == 0) ? CH_NUL : any_byte();
            end else if (pick < 17 && text_buf.size() > 1) begin
                void'(text_buf.pop_back());
            end
        end
    endtask

    task automatic queue_text();
        pending_char_t p;
        foreach (text_buf[i]) begin
            p.data.text_char = text_buf[i];
            p.data.end_of_string = (i == text_buf.size() - 1);
            p.gap_after = pick_gap();
            chars_to_send.push_back(p);
        end
    endtask

    task automatic queue_literal(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        queue_text();
    endtask

    task automatic wait_sent();
        while (chars_to_send.size() != 0) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        pending_char_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !char_taken) begin
            s_valid <= 1'b1;
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
        end else if (chars_to_send.size() > 0) begin
            cur = chars_to_send.pop_front();
            s_data <= cur.data;
            s_valid <= 1'b1;
            gap_left = cur.gap_after;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        char_taken = aresetn && s_valid && s_ready;
        if (char_taken) predict_tokens(s_data);
        if (aresetn && m_valid && m_ready) check_token(m_data);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_level = 1;
        queue_literal(".()+?!*-[]");
        queue_literal("a | b");
        queue_literal(" ");
        queue_literal(" |");
        queue_literal(" |x");
        queue_literal("'\\''");
        queue_literal("{a..z}");
        queue_literal("\"a\\\"b\"");
        queue_literal("'");
        queue_literal("#ab");
        text_buf.delete();
        text_buf.push_back(CH_NUL);
        queue_text();
        text_buf.delete();
        text_buf.push_back(8'hFF);
        queue_text();
        wait_sent();

        for (int phase = 0; phase < 6; phase++) begin
            idle_level = phase % 3;
            sent = 0;
            while (sent < 16) begin
                build_random_text();
                sent += text_buf.size();
                queue_text();
            end
            wait_sent();
        end

        while (chars_to_send.size() != 0 || s_valid || expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/core/gnt_pkg.sv
rtl/core/gnt_scan.sv
rtl/core/gnt_res_fifo.sv
rtl/core/grammar_notation_tokenizer.sv
bench/tb_top.sv
